FILE: sv/ffca_pkg.sv
// ffca_pkg: shared types, codes and arithmetic helpers of the first-fit chunk allocator.
// Used by the chunk cells, the chain, the fit probe and the top level.
package ffca_pkg;

  localparam int AW = 32;   // offset and length width
  localparam int XW = 36;   // headroom for rounded offsets and ends
  localparam int TW = 16;   // chunk tag width
  localparam int KW = 2;    // resource kind width

  localparam logic [KW-1:0] KIND_FREE    = 2'd0;
  localparam logic [KW-1:0] KIND_OPTIMAL = 2'd3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic CFG_BLOCK = 1'b0;
  localparam logic CFG_GRAN  = 1'b1;

  localparam logic [AW-1:0] BLOCK_RESET = 32'd65536;
  localparam logic [AW-1:0] GRAN_RESET  = 32'd1;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] len;
    logic [KW-1:0] kind;
    logic [TW-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic [AW-1:0] size;
    logic [AW-1:0] align;
    logic [KW-1:0] kind;
    logic [AW-1:0] gran;
  } req_t;

  typedef struct packed {
    logic [XW-1:0] off;
    logic [XW-1:0] endsz;
    logic [XW-1:0] cend;
    logic [AW-1:0] start;
    logic [TW-1:0] tag;
  } hit_t;

  // (x + a - 1) with the bits of (a - 1) cleared; zero alignment acts as one
  function automatic logic [XW-1:0] round_up(input logic [XW-1:0] x, input logic [AW-1:0] a);
    logic [XW-1:0] m;
    m = (a == '0) ? '0 : XW'(a - AW'(1));
    return (x + m) & ~m;
  endfunction

  function automatic logic same_page(input logic [XW-1:0] e, input logic [XW-1:0] s,
                                     input logic [AW-1:0] g);
    logic [XW-1:0] m;
    m = ~((g == '0) ? '0 : XW'(g - AW'(1)));
    return (e & m) >= (s & m);
  endfunction

  function automatic logic kinds_conflict(input logic [KW-1:0] a, input logic [KW-1:0] b);
    if (a == KIND_FREE || b == KIND_FREE) begin
      return 1'b0;
    end
    return (a == KIND_OPTIMAL) != (b == KIND_OPTIMAL);
  endfunction

endpackage

FILE: sv/ffca_cell.sv
// ffca_cell: one chunk-table entry that takes its neighbor's entry on every shift unless it is loaded.
// Depends on ffca_pkg.
module ffca_cell import ffca_pkg::*; (
  input  logic   clk,
  input  logic   shift,
  input  logic   load,
  input  entry_t load_d,
  input  entry_t d_in,
  output entry_t q
);

  entry_t q_r;

  always_ff @(posedge clk) begin
    if (load) begin
      q_r <= load_d;
    end else if (shift) begin
      q_r <= d_in;
    end
  end

  assign q = q_r;

endmodule

FILE: sv/ffca_chain.sv
// ffca_chain: ring of chunk cells; entries move one cell toward the head per shift.
// Depends on ffca_pkg and ffca_cell.
module ffca_chain import ffca_pkg::*; #(
  parameter int MAX_CHUNKS = 64
) (
  input  logic   clk,
  input  logic   shift,
  input  logic   load,
  input  entry_t load_d,
  input  entry_t tail_d,
  output entry_t head0,
  output entry_t head1,
  output entry_t head2
);

  localparam int L1 = (MAX_CHUNKS > 1) ? 1 : 0;
  localparam int L2 = (MAX_CHUNKS > 2) ? 2 : L1;

  entry_t q [MAX_CHUNKS];

  for (genvar k = 0; k < MAX_CHUNKS; k++) begin : g_cell
    entry_t d_k;
    if (k == MAX_CHUNKS - 1) begin : g_tail
      assign d_k = tail_d;
    end else begin : g_mid
      assign d_k = q[k+1];
    end
    ffca_cell u_cell (
      .clk    (clk),
      .shift  (shift),
      .load   (load && (k == 0)),
      .load_d (load_d),
      .d_in   (d_k),
      .q      (q[k])
    );
  end

  assign head0 = q[0];
  assign head1 = q[L1];
  assign head2 = q[L2];

endmodule

FILE: sv/ffca_probe.sv
// ffca_probe: pipelined first-fit test of the entries streaming past the chain head.
// Depends on ffca_pkg. Four stages: align, page push, end, fit and capture.
module ffca_probe import ffca_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   clr,
  input  logic   scan,
  input  logic   has_prev,
  input  logic   has_next,
  input  entry_t cur,
  input  entry_t prev,
  input  entry_t next,
  input  req_t   req,
  output logic   found,
  output hit_t   hit
);

  logic          v1_r, v2_r, v3_r, found_r;
  logic [XW-1:0] off1_r, pend1_r, cend1_r, off2_r, cend2_r, off3_r, endsz3_r, cend3_r;
  logic          cp1_r, cn1_r, cn2_r, cn3_r;
  logic [AW-1:0] nst1_r, nst2_r, nst3_r, st1_r, st2_r, st3_r;
  logic [TW-1:0] tag1_r, tag2_r, tag3_r;
  hit_t          hit_r;

  logic elig, fit, sp, take;

  assign elig = scan && (cur.kind == KIND_FREE) && (cur.len >= req.size);
  assign fit  = endsz3_r <= cend3_r;
  assign sp   = same_page(endsz3_r - XW'(1), XW'(nst3_r), req.gran);
  assign take = v3_r && fit && !(cn3_r && sp) && !found_r;

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      v1_r <= elig;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (take) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    off1_r  <= round_up(XW'(cur.start), req.align);
    pend1_r <= XW'(prev.start) + XW'(prev.len) - XW'(1);
    cp1_r   <= has_prev && kinds_conflict(prev.kind, req.kind);
    cn1_r   <= has_next && kinds_conflict(req.kind, next.kind);
    nst1_r  <= next.start;
    cend1_r <= XW'(cur.start) + XW'(cur.len);
    st1_r   <= cur.start;
    tag1_r  <= cur.tag;

    // push to a page boundary when the previous conflicting chunk ends in the same page
    off2_r  <= (cp1_r && same_page(pend1_r, off1_r, req.gran)) ?
               round_up(off1_r, req.gran) : off1_r;
    cn2_r   <= cn1_r;
    nst2_r  <= nst1_r;
    cend2_r <= cend1_r;
    st2_r   <= st1_r;
    tag2_r  <= tag1_r;

    off3_r   <= off2_r;
    endsz3_r <= off2_r + XW'(req.size);
    cn3_r    <= cn2_r;
    nst3_r   <= nst2_r;
    cend3_r  <= cend2_r;
    st3_r    <= st2_r;
    tag3_r   <= tag2_r;

    if (take) begin
      hit_r.off   <= off3_r;
      hit_r.endsz <= endsz3_r;
      hit_r.cend  <= cend3_r;
      hit_r.start <= st3_r;
      hit_r.tag   <= tag3_r;
    end
  end

  assign found = found_r;
  assign hit   = hit_r;

endmodule

FILE: sv/first_fit_chunk_allocator.sv
// first_fit_chunk_allocator: first-fit chunk table with split and coalescing on free.
// One request at a time, taken again the cycle after the result loads. Unless rejected up
// front, the cell ring rotates once to scan and, when the table changes, once more to insert,
// modify or erase entries.
// Reset (rst_n low, synchronous) or a block_bytes write: one free chunk, nothing in use, id 1.
module first_fit_chunk_allocator import ffca_pkg::*; #(
  parameter int MAX_CHUNKS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_idx,
  input  logic [AW-1:0] cfg_wdata,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_command,
  input  logic [AW-1:0] in_request_bytes,
  input  logic [AW-1:0] in_align_bytes,
  input  logic [KW-1:0] in_resource_kind,
  input  logic [TW-1:0] in_release_id,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic [AW-1:0] out_start_offset,
  output logic [TW-1:0] out_granted_id,
  output logic [AW-1:0] out_bytes_in_use
);

  localparam int PW = $clog2(MAX_CHUNKS);
  localparam int CW = PW + 1;
  localparam logic [PW-1:0] P_LAST = PW'(MAX_CHUNKS - 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_DRAIN  = 6'b000100,
    S_DECIDE = 6'b001000,
    S_EDIT   = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    EM_MOD   = 2'd0,
    EM_SPLIT = 2'd1,
    EM_FREE  = 2'd2
  } emode_t;

  state_t state_r, state_nxt;

  logic          cmd_r;
  req_t          req_r;
  logic [TW-1:0] rel_r;
  logic [AW-1:0] block_r, used_r;
  logic [CW-1:0] count_r;
  logic [TW-1:0] next_tag_r;
  logic [PW-1:0] p_r;
  logic [1:0]    drain_r;
  entry_t        dly_r;

  logic          ffound_r, fprev_r, fnext_r;
  logic [PW-1:0] fidx_r;
  logic [AW-1:0] fprevlen_r, flen_r, fnextlen_r;

  // the probe reports its hit index through the scan position at capture time
  logic [PW-1:0] hidx_r;
  logic [PW-1:0] p_d1_r, p_d2_r, p_d3_r;

  emode_t        emode_r;
  logic [PW-1:0] eidx_r;
  logic [KW-1:0] ekind_r;
  logic [AW-1:0] elen_r;
  logic [1:0]    eskip_r;
  entry_t        etail_r;

  logic [1:0]    res_status_r;
  logic [AW-1:0] res_off_r, res_used_r;
  logic [TW-1:0] res_id_r;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [AW-1:0] out_off_r, out_used_r;
  logic [TW-1:0] out_id_r;

  entry_t head0, head1, head2, tail_d, edit_d, init_d;
  logic   shift, init_load, accept, pre_fail, room_short, in_range, has_next, fmatch;
  logic   found, split;
  hit_t   hit;
  logic [XW-1:0] padded;
  logic [AW-1:0] merged_len;
  logic [CW-1:0] p_ext;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign shift     = (state_r == S_SCAN) || (state_r == S_EDIT);
  assign init_load = !rst_n || (cfg_we && cfg_idx == CFG_BLOCK);
  assign p_ext     = {1'b0, p_r};
  assign in_range  = p_ext < count_r;
  assign has_next  = (p_ext + CW'(1)) < count_r;

  assign init_d.start = '0;
  assign init_d.len   = rst_n ? cfg_wdata : BLOCK_RESET;
  assign init_d.kind  = KIND_FREE;
  assign init_d.tag   = '0;

  assign room_short = (used_r <= block_r) && ((block_r - used_r) < in_request_bytes);
  assign pre_fail   = (in_command == CMD_ALLOC) &&
                      ((in_request_bytes == '0) || (in_resource_kind == KIND_FREE) || room_short);

  assign fmatch = (state_r == S_SCAN) && (cmd_r == CMD_FREE) && in_range && !ffound_r &&
                  (head0.tag == rel_r) && (head0.kind != KIND_FREE);

  assign split      = hit.cend > hit.endsz;
  assign padded     = hit.endsz - XW'(hit.start);
  assign merged_len = (fprev_r ? fprevlen_r : '0) + flen_r + (fnext_r ? fnextlen_r : '0);

  ffca_chain #(.MAX_CHUNKS(MAX_CHUNKS)) u_chain (
    .clk    (clk),
    .shift  (shift),
    .load   (init_load),
    .load_d (init_d),
    .tail_d (tail_d),
    .head0  (head0),
    .head1  (head1),
    .head2  (head2)
  );

  ffca_probe u_probe (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (accept),
    .scan     ((state_r == S_SCAN) && (cmd_r == CMD_ALLOC) && in_range),
    .has_prev (p_r != '0),
    .has_next (has_next),
    .cur      (head0),
    .prev     (dly_r),
    .next     (head1),
    .req      (req_r),
    .found    (found),
    .hit      (hit)
  );

  // entry written back at the tail during the edit pass
  always_comb begin
    edit_d = head0;
    case (emode_r)
      EM_MOD: begin
        if (p_r == eidx_r) begin
          edit_d.len  = elen_r;
          edit_d.kind = ekind_r;
        end
      end
      EM_SPLIT: begin
        if (p_r == eidx_r) begin
          edit_d.len  = elen_r;
          edit_d.kind = ekind_r;
        end else if (p_ext == ({1'b0, eidx_r} + CW'(1))) begin
          edit_d = etail_r;
        end else if (p_r > eidx_r) begin
          edit_d = dly_r;
        end
      end
      EM_FREE: begin
        if (p_r == eidx_r) begin
          edit_d.len  = elen_r;
          edit_d.kind = KIND_FREE;
        end else if (p_r > eidx_r) begin
          if (eskip_r == 2'd1) begin
            edit_d = head1;
          end else if (eskip_r == 2'd2) begin
            edit_d = head2;
          end
        end
      end
      default: edit_d = head0;
    endcase
  end

  assign tail_d = (state_r == S_EDIT) ? edit_d : head0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = pre_fail ? S_DONE : S_SCAN;
      S_SCAN:   if (p_r == P_LAST) state_nxt = S_DRAIN;
      S_DRAIN:  if (drain_r == 2'd3) state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (cmd_r == CMD_ALLOC) begin
          state_nxt = (!found || (split && count_r == CW'(MAX_CHUNKS))) ? S_DONE : S_EDIT;
        end else begin
          state_nxt = ffound_r ? S_EDIT : S_DONE;
        end
      end
      S_EDIT:   if (p_r == P_LAST) state_nxt = S_DONE;
      S_DONE:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      block_r     <= BLOCK_RESET;
      req_r.gran  <= GRAN_RESET;
      count_r     <= CW'(1);
      used_r      <= '0;
      next_tag_r  <= TW'(1);
      p_r         <= '0;
      drain_r     <= '0;
      ffound_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we && cfg_idx == CFG_BLOCK) begin
        block_r    <= cfg_wdata;
        count_r    <= CW'(1);
        used_r     <= '0;
        next_tag_r <= TW'(1);
      end
      if (cfg_we && cfg_idx == CFG_GRAN) begin
        req_r.gran <= cfg_wdata;
      end
      if (accept) begin
        req_r.size  <= in_request_bytes;
        req_r.align <= in_align_bytes;
        req_r.kind  <= in_resource_kind;
      end
      if (accept) begin
        ffound_r <= 1'b0;
      end else if (fmatch) begin
        ffound_r <= 1'b1;
      end
      if (shift) begin
        p_r <= (p_r == P_LAST) ? '0 : p_r + PW'(1);
      end
      drain_r <= (state_r == S_DRAIN) ? drain_r + 2'd1 : 2'd0;
      if (state_r == S_DECIDE) begin
        if (cmd_r == CMD_ALLOC) begin
          if (found && !(split && count_r == CW'(MAX_CHUNKS))) begin
            used_r <= used_r + padded[AW-1:0];
            if (split) begin
              count_r    <= count_r + CW'(1);
              next_tag_r <= next_tag_r + TW'(1);
            end
          end
        end else if (ffound_r) begin
          used_r  <= used_r - flen_r;
          count_r <= count_r - CW'(fprev_r) - CW'(fnext_r);
        end
      end
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= in_command;
      rel_r      <= in_release_id;
      res_status_r <= ST_NOFIT;
      res_off_r  <= '0;
      res_id_r   <= '0;
      res_used_r <= used_r;
    end
    if (shift) begin
      dly_r <= head0;
    end
    if (fmatch) begin
      fidx_r     <= p_r;
      fprev_r    <= (p_r != '0) && (dly_r.kind == KIND_FREE);
      fprevlen_r <= dly_r.len;
      flen_r     <= head0.len;
      fnext_r    <= has_next && (head1.kind == KIND_FREE);
      fnextlen_r <= head1.len;
    end
    if (state_r == S_DECIDE) begin
      if (cmd_r == CMD_ALLOC) begin
        emode_r       <= split ? EM_SPLIT : EM_MOD;
        eidx_r        <= hidx_r;
        ekind_r       <= req_r.kind;
        elen_r        <= padded[AW-1:0];
        eskip_r       <= 2'd0;
        etail_r.start <= hit.endsz[AW-1:0];
        etail_r.len   <= AW'(hit.cend - hit.endsz);
        etail_r.kind  <= KIND_FREE;
        etail_r.tag   <= next_tag_r;
        if (!found) begin
          res_status_r <= ST_NOFIT;
        end else if (split && count_r == CW'(MAX_CHUNKS)) begin
          res_status_r <= ST_FULL;
        end else begin
          res_status_r <= ST_OK;
          res_off_r    <= hit.off[AW-1:0];
          res_id_r     <= hit.tag;
          res_used_r   <= used_r + padded[AW-1:0];
        end
      end else begin
        emode_r <= EM_FREE;
        eidx_r  <= fprev_r ? fidx_r - PW'(1) : fidx_r;
        ekind_r <= KIND_FREE;
        elen_r  <= merged_len;
        eskip_r <= {1'b0, fprev_r} + {1'b0, fnext_r};
        if (ffound_r) begin
          res_status_r <= ST_OK;
          res_used_r   <= used_r - flen_r;
        end else begin
          res_status_r <= ST_NOTFOUND;
        end
      end
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_status_r <= res_status_r;
      out_off_r    <= res_off_r;
      out_id_r     <= res_id_r;
      out_used_r   <= res_used_r;
    end
  end

  always_ff @(posedge clk) begin
    p_d1_r <= p_r;
    p_d2_r <= p_d1_r;
    p_d3_r <= p_d2_r;
    if (!found && state_r != S_IDLE) begin
      hidx_r <= p_d3_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_start_offset = out_off_r;
  assign out_granted_id   = out_id_r;
  assign out_bytes_in_use = out_used_r;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CW'(MAX_CHUNKS)))
    else $error("chunk count out of range");

  a_ring_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (p_r == '0))
    else $error("cell ring not aligned while idle");

  a_edit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EDIT) && (p_r == P_LAST) |=> (state_r == S_DONE))
    else $error("edit pass did not end after one rotation");
`endif

endmodule
